// ===== rtl/porq_pkg.sv =====
// Package for the sorted ready queue: entry type, cell command bundle,
// queue depth and the rank compare shared by the cells.
// No dependencies.
`default_nettype none

package porq_pkg;

    localparam int unsigned DEPTH = 32;

    localparam int unsigned ID_W   = 15;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned TIME_W = 32;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] rtime;
    } t_entry;

    // Broadcast to every cell in the cycle an item is taken.
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry ent;
    } t_cmd;

    // True when stored entry s ranks strictly below new entry n.
    function automatic logic ranks_below(input t_entry s, input t_entry n);
        logic res;
        if (s.prio != n.prio) begin
            res = (s.prio < n.prio);
        end else if (s.rtime != n.rtime) begin
            res = (s.rtime > n.rtime);
        end else begin
            res = (s.id > n.id);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/porq_cell.sv =====
// One slot of the sorted queue: holds an entry and its valid flag,
// shifts right on insert below the new entry, shifts left on pop.
// Depends on porq_pkg.
`default_nettype none

module porq_cell
    import porq_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cmd   i_cmd,
    input  wire t_entry i_left_entry,
    input  wire logic   i_left_valid,
    input  wire logic   i_left_below,
    input  wire t_entry i_right_entry,
    input  wire logic   i_right_valid,
    output t_entry      o_entry,
    output logic        o_valid,
    output logic        o_below
);

    t_entry r_entry, n_entry;
    logic   r_valid, n_valid;
    logic   below;

    assign below = !r_valid || ranks_below(r_entry, i_cmd.ent);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_cmd.ins && below) begin
            if (i_left_below) begin
                // neighbor also moves: take its entry
                n_entry = i_left_entry;
                n_valid = i_left_valid;
            end else begin
                // first slot below the new entry: place it here
                n_entry = i_cmd.ent;
                n_valid = 1'b1;
            end
        end else if (i_cmd.pop) begin
            n_entry = i_right_entry;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_below = below;

endmodule

`default_nettype wire

// ===== rtl/priority_ordered_ready_queue_top.sv =====
// Top level of the sorted ready queue: row of porq_cell slots plus the
// registered status result. Depends on porq_pkg and porq_cell.
//
// Usage:
//   Command channel: drive i_func, i_proc_id, i_prio, i_remaining_time
//   with start high; the command transfers on a rising edge where start
//   is high and busy is low. busy stays low, so one command can be taken
//   every cycle.
//   i_func = insert places the entry in rank order (higher priority, then
//   smaller remaining time, then smaller id; ties go after stored ones);
//   a full queue drops it and reports o_overflow. i_func = pop removes
//   the head and returns it with o_head_valid.
//   Result channel: one result per command, on the output ports for one
//   cycle with strobe high, in the cycle after the command transfers.
//   The receiver cannot stall; results must be taken.
//   Throughput: one command per cycle. Every slot compares its entry with
//   the new one at once and shifts to a neighbor, so the cycle is set by
//   one 55-bit rank compare and a mux per slot.
//   Reset (synchronous, active low) empties the queue and clears strobe.
`default_nettype none

module priority_ordered_ready_queue_top
    import porq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_func,
    input  wire logic [ID_W-1:0]   i_proc_id,
    input  wire logic [PRIO_W-1:0] i_prio,
    input  wire logic [TIME_W-1:0] i_remaining_time,
    output logic                   strobe,
    output logic                   o_head_valid,
    output logic [ID_W-1:0]        o_head_id,
    output logic [PRIO_W-1:0]      o_head_prio,
    output logic [TIME_W-1:0]      o_head_time,
    output logic                   o_overflow,
    output logic                   o_now_empty
);

    t_cmd   cmd;
    t_entry new_entry;
    t_entry cell_entry [DEPTH];
    logic   cell_valid [DEPTH];
    logic   cell_below [DEPTH];

    logic accept, full, is_pop;

    logic   r_strobe;
    logic   r_head_valid, n_head_valid;
    t_entry r_head, n_head;
    logic   r_overflow, n_overflow;
    logic   r_now_empty, n_now_empty;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = cell_valid[DEPTH-1];
    assign is_pop = (i_func == FUNC_POP);

    assign new_entry.id    = i_proc_id;
    assign new_entry.prio  = i_prio;
    assign new_entry.rtime = i_remaining_time;

    assign cmd.ins = accept && (i_func == FUNC_INSERT) && !full;
    assign cmd.pop = accept && is_pop;
    assign cmd.ent = new_entry;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry left_entry, right_entry;
        logic   left_valid, left_below, right_valid;

        if (g == 0) begin : g_first
            assign left_entry = new_entry;
            assign left_valid = 1'b0;
            assign left_below = 1'b0;
        end else begin : g_mid
            assign left_entry = cell_entry[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_below = cell_below[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_entry = new_entry;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_entry = cell_entry[g+1];
            assign right_valid = cell_valid[g+1];
        end

        porq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_left_entry  (left_entry),
            .i_left_valid  (left_valid),
            .i_left_below  (left_below),
            .i_right_entry (right_entry),
            .i_right_valid (right_valid),
            .o_entry       (cell_entry[g]),
            .o_valid       (cell_valid[g]),
            .o_below       (cell_below[g])
        );
    end

    always_comb begin
        n_head_valid = 1'b0;
        n_head       = '0;
        n_overflow   = 1'b0;
        n_now_empty  = 1'b0;
        if (is_pop) begin
            if (cell_valid[0]) begin
                n_head_valid = 1'b1;
                n_head       = cell_entry[0];
            end
            n_now_empty = !cell_valid[1];
        end else begin
            // an insert always leaves at least one entry
            n_overflow = full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head_valid <= n_head_valid;
            r_head       <= n_head;
            r_overflow   <= n_overflow;
            r_now_empty  <= n_now_empty;
        end
    end

    assign strobe       = r_strobe;
    assign o_head_valid = r_head_valid;
    assign o_head_id    = r_head.id;
    assign o_head_prio  = r_head.prio;
    assign o_head_time  = r_head.rtime;
    assign o_overflow   = r_overflow;
    assign o_now_empty  = r_now_empty;

endmodule

`default_nettype wire
